FILE: hw/rtl/pph_pkg.sv
// Package for the pulse period histogram: command codes, window offset,
// reset values and default sizes. Used by the top level and the testbench.
// Depends on nothing.
package pph_pkg;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_START   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam int unsigned DEF_NUM_BINS      = 100;
  localparam int unsigned DEF_MAX_INTERVALS = 1000;

  localparam logic [15:0] WINDOW_OFFSET  = 16'd50;
  localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SEL_W    = 7;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned CFG_W    = 16;

endpackage

FILE: hw/rtl/pph_ram.sv
// Single-port-write, single-port-read synchronous memory for the bin counts.
// Read data is registered and shows the contents before a same-edge write.
// Depends on nothing.
module pph_ram #(
  parameter int unsigned Depth = 100,
  parameter int unsigned AddrW = 7,
  parameter int unsigned DataW = 32
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/pulse_period_histogram.sv
// Top level of the pulse period histogram: request pipeline, run control and
// bin count read-modify-write. Depends on pph_pkg and pph_ram.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_ready  | cmd, timestamp, bin_select
//  out_    | output    | out_valid/out_ready| interval, in_window, bin_index,
//          |           |                    | bin_period, bin_count, run_done
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data (expected period)
//
// One request per cycle is accepted while in_ready is high; each gives its result
// through a decode stage, a bin memory read stage and the output register.
// Same-bin updates on consecutive requests are forwarded around the memory.
// After reset the bin memory is cleared address by address, during which
// in_ready stays low; configuration writes are taken throughout.
// A stalled output holds the pipeline and in_ready drops only when it is full.
module pulse_period_histogram #(
  parameter int unsigned NUM_BINS      = pph_pkg::DEF_NUM_BINS,
  parameter int unsigned MAX_INTERVALS = pph_pkg::DEF_MAX_INTERVALS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pph_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_cmd,
  input  logic [pph_pkg::TS_W-1:0]       in_timestamp,
  input  logic [pph_pkg::SEL_W-1:0]      in_bin_select,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pph_pkg::TS_W-1:0]       out_interval,
  output logic                           out_in_window,
  output logic [pph_pkg::SEL_W-1:0]      out_bin_index,
  output logic [pph_pkg::PERIOD_W-1:0]   out_bin_period,
  output logic [pph_pkg::COUNT_W-1:0]    out_bin_count,
  output logic                           out_run_done
);

  localparam int unsigned AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned WW  = (AW > pph_pkg::SEL_W) ? AW : pph_pkg::SEL_W;
  localparam int unsigned CW  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned TW  = pph_pkg::TS_W;
  localparam int unsigned NW  = pph_pkg::COUNT_W;
  localparam int unsigned SW  = pph_pkg::SEL_W;
  localparam int unsigned PW  = pph_pkg::PERIOD_W;
  localparam int unsigned EW  = pph_pkg::CFG_W;
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_INTERVALS);
  localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

  // Configuration and run state.
  logic [EW-1:0] period_r;
  logic [TW-1:0] last_ts_r;
  logic [CW-1:0] taken_r;
  logic [CW-1:0] taken_nxt;
  logic [TW-1:0] last_ts_nxt;
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  // Decode stage.
  logic              s1_valid_r;
  pph_pkg::cmd_t     s1_cmd_r;
  logic              s1_meas_r;
  logic [TW-1:0]     s1_iv_r;
  logic [SW-1:0]     s1_sel_r;
  logic [EW-1:0]     s1_start_r;
  logic              s1_done_r;

  // Memory read stage.
  logic              s2_valid_r;
  pph_pkg::cmd_t     s2_cmd_r;
  logic              s2_meas_r;
  logic              s2_hit_r;
  logic [TW-1:0]     s2_iv_r;
  logic [AW-1:0]     s2_addr_r;
  logic [SW-1:0]     s2_idx_r;
  logic [PW-1:0]     s2_period_r;
  logic              s2_inrange_r;
  logic              s2_done_r;
  logic              s2_fwd_r;
  logic [NW-1:0]     s2_fwd_data_r;

  // Output register.
  logic              out_valid_r;
  logic [TW-1:0]     out_interval_r;
  logic              out_in_window_r;
  logic [SW-1:0]     out_bin_index_r;
  logic [PW-1:0]     out_bin_period_r;
  logic [NW-1:0]     out_bin_count_r;
  logic              out_run_done_r;
  logic [TW-1:0]     out_interval_nxt;
  logic              out_in_window_nxt;
  logic [SW-1:0]     out_bin_index_nxt;
  logic [PW-1:0]     out_bin_period_nxt;
  logic [NW-1:0]     out_bin_count_nxt;
  logic              out_run_done_nxt;

  logic          out_free;
  logic          s2_adv;
  logic          s2_free;
  logic          s1_adv;
  logic          s1_free;
  logic          in_acc;
  pph_pkg::cmd_t in_cmd_e;
  logic          done_now;
  logic          meas_nxt;
  logic [EW-1:0] start_nxt;

  logic [TW-1:0] s1_diff;
  logic          s1_hit;
  logic [WW-1:0] s1_sel_w;
  logic [AW-1:0] s1_addr;
  logic          s1_inrange;
  logic [PW-1:0] s1_period;

  logic [NW-1:0] rd_data;
  logic [NW-1:0] s2_count;
  logic [NW-1:0] s2_count_inc;
  logic          upd_wr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [NW-1:0] mem_wr_data;

  assign out_free = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = !clr_active_r && s1_free;
  assign in_acc   = in_valid && in_ready;
  assign in_cmd_e = pph_pkg::cmd_t'(in_cmd);

  assign done_now  = (taken_r >= MAX_CNT);
  assign start_nxt = (period_r < pph_pkg::WINDOW_OFFSET) ? '0
                     : (period_r - pph_pkg::WINDOW_OFFSET);

  always_comb begin
    taken_nxt   = taken_r;
    last_ts_nxt = last_ts_r;
    meas_nxt    = 1'b0;
    unique case (in_cmd_e)
      pph_pkg::CMD_CAPTURE: begin
        if (!done_now) begin
          last_ts_nxt = in_timestamp;
          if (last_ts_r != '0) begin
            taken_nxt = taken_r + CW'(1);
            meas_nxt  = 1'b1;
          end
        end
      end
      pph_pkg::CMD_START: begin
        taken_nxt = '0;
      end
      pph_pkg::CMD_READ, pph_pkg::CMD_NONE: begin
        taken_nxt = taken_r;
      end
      default: begin
        taken_nxt = taken_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= pph_pkg::PERIOD_DEFAULT;
      last_ts_r    <= '0;
      taken_r      <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (in_acc) begin
        last_ts_r <= last_ts_nxt;
        taken_r   <= taken_nxt;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_BIN) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // Decode stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_cmd_e;
      s1_meas_r  <= meas_nxt;
      s1_iv_r    <= in_timestamp - last_ts_r;
      s1_sel_r   <= in_bin_select;
      s1_start_r <= start_nxt;
      s1_done_r  <= (in_cmd_e == pph_pkg::CMD_START) ? 1'b0 : (taken_nxt >= MAX_CNT);
    end
  end

  assign s1_diff    = s1_iv_r - TW'(s1_start_r);
  assign s1_hit     = s1_meas_r && (s1_iv_r >= TW'(s1_start_r))
                      && (s1_diff < TW'(NUM_BINS));
  assign s1_sel_w   = WW'(s1_sel_r);
  assign s1_inrange = (TW'(s1_sel_r) < TW'(NUM_BINS));
  assign s1_addr    = s1_hit ? s1_diff[AW-1:0] : s1_sel_w[AW-1:0];
  assign s1_period  = PW'(s1_start_r) + PW'(s1_sel_r);

  // Memory read stage: the count arrives from memory or from the update
  // that was written back on the same edge as the read.
  assign s2_count     = s2_fwd_r ? s2_fwd_data_r : rd_data;
  assign s2_count_inc = s2_count + NW'(1);
  assign upd_wr       = s2_adv && s2_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_cmd_r      <= s1_cmd_r;
      s2_meas_r     <= s1_meas_r;
      s2_hit_r      <= s1_hit;
      s2_iv_r       <= s1_iv_r;
      s2_addr_r     <= s1_addr;
      s2_idx_r      <= s1_hit ? s1_diff[SW-1:0] : s1_sel_r;
      s2_period_r   <= s1_hit ? s1_iv_r[PW-1:0] : s1_period;
      s2_inrange_r  <= s1_inrange;
      s2_done_r     <= s1_done_r;
      s2_fwd_r      <= upd_wr && (s2_addr_r == s1_addr);
      s2_fwd_data_r <= s2_count_inc;
    end
  end

  assign mem_wr_en   = clr_active_r || upd_wr;
  assign mem_wr_addr = clr_active_r ? clr_addr_r : s2_addr_r;
  assign mem_wr_data = clr_active_r ? '0 : s2_count_inc;

  pph_ram #(
    .Depth (NUM_BINS),
    .AddrW (AW),
    .DataW (NW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (s1_adv),
    .rd_addr (s1_addr),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_adv;
    end
  end

  always_comb begin
    out_interval_nxt   = '0;
    out_in_window_nxt  = 1'b0;
    out_bin_index_nxt  = '0;
    out_bin_period_nxt = '0;
    out_bin_count_nxt  = '0;
    out_run_done_nxt   = s2_done_r;
    unique case (s2_cmd_r)
      pph_pkg::CMD_CAPTURE: begin
        if (s2_meas_r) begin
          out_interval_nxt = s2_iv_r;
        end
        if (s2_hit_r) begin
          out_in_window_nxt  = 1'b1;
          out_bin_index_nxt  = s2_idx_r;
          out_bin_period_nxt = s2_period_r;
          out_bin_count_nxt  = s2_count_inc;
        end
      end
      pph_pkg::CMD_READ: begin
        out_bin_index_nxt  = s2_idx_r;
        out_bin_period_nxt = s2_period_r;
        if (s2_inrange_r) begin
          out_bin_count_nxt = s2_count;
        end
      end
      pph_pkg::CMD_START: begin
        out_run_done_nxt = 1'b0;
      end
      pph_pkg::CMD_NONE: begin
        out_run_done_nxt = s2_done_r;
      end
      default: begin
        out_run_done_nxt = s2_done_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_interval_r   <= out_interval_nxt;
      out_in_window_r  <= out_in_window_nxt;
      out_bin_index_r  <= out_bin_index_nxt;
      out_bin_period_r <= out_bin_period_nxt;
      out_bin_count_r  <= out_bin_count_nxt;
      out_run_done_r   <= out_run_done_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_interval   = out_interval_r;
  assign out_in_window  = out_in_window_r;
  assign out_bin_index  = out_bin_index_r;
  assign out_bin_period = out_bin_period_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_run_done   = out_run_done_r;

endmodule

FILE: tb/pph_tb_pkg.sv
// Scoreboard for the pulse period histogram testbench: the result record and a class
// that predicts each result from the accepted requests and checks what the block returns.
// Depends on pph_pkg.
package pph_tb_pkg;

  localparam int unsigned HIST_BINS  = pph_pkg::DEF_NUM_BINS;
  localparam int unsigned RUN_LENGTH = pph_pkg::DEF_MAX_INTERVALS;

  typedef struct packed {
    logic [pph_pkg::TS_W-1:0]     interval;
    logic                         in_window;
    logic [pph_pkg::SEL_W-1:0]    bin_index;
    logic [pph_pkg::PERIOD_W-1:0] bin_period;
    logic [pph_pkg::COUNT_W-1:0]  bin_count;
    logic                         run_done;
  } hist_result_t;

  class histogram_scoreboard;
    logic [pph_pkg::CFG_W-1:0]   period;
    logic [pph_pkg::TS_W-1:0]    last_stamp;
    logic [pph_pkg::COUNT_W-1:0] bin_tally [HIST_BINS];
    int unsigned                 taken;
    hist_result_t                awaited_results [$];
    int unsigned                 errors;
    int unsigned                 requests;
    int unsigned                 checked;
    int unsigned                 hits;
    int unsigned                 finished;

    function new();
      period     = pph_pkg::PERIOD_DEFAULT;
      last_stamp = '0;
      taken      = 0;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      errors   = 0;
      requests = 0;
      checked  = 0;
      hits     = 0;
      finished = 0;
    endfunction

    // A period below the offset clamps the window to start at zero.
    function logic [pph_pkg::TS_W-1:0] window_base();
      return (period < pph_pkg::WINDOW_OFFSET) ? '0
             : pph_pkg::TS_W'(period - pph_pkg::WINDOW_OFFSET);
    endfunction

    function bit run_over();
      return taken >= RUN_LENGTH;
    endfunction

    function void note_request(pph_pkg::cmd_t c, logic [pph_pkg::TS_W-1:0] stamp,
                               logic [pph_pkg::SEL_W-1:0] sel);
      hist_result_t              r;
      logic [pph_pkg::TS_W-1:0]  base;
      logic [pph_pkg::TS_W-1:0]  gap;
      logic [pph_pkg::TS_W-1:0]  offs;
      r    = '0;
      base = window_base();
      case (c)
        pph_pkg::CMD_CAPTURE: begin
          if (!run_over()) begin
            if (last_stamp == '0) begin
              last_stamp = stamp;
            end else begin
              gap        = stamp - last_stamp;
              last_stamp = stamp;
              taken++;
              r.interval = gap;
              offs       = gap - base;
              if (gap >= base && offs < HIST_BINS) begin
                bin_tally[offs] = bin_tally[offs] + 1'b1;
                r.in_window     = 1'b1;
                r.bin_index     = offs[pph_pkg::SEL_W-1:0];
                r.bin_period    = gap[pph_pkg::PERIOD_W-1:0];
                r.bin_count     = bin_tally[offs];
              end
            end
          end
          r.run_done = run_over();
        end
        pph_pkg::CMD_READ: begin
          r.bin_index  = sel;
          r.bin_period = pph_pkg::PERIOD_W'(base + sel);
          if (sel < HIST_BINS) r.bin_count = bin_tally[sel];
          r.run_done = run_over();
        end
        pph_pkg::CMD_START: begin
          taken = 0;
        end
        default: begin
          r.run_done = run_over();
        end
      endcase
      requests++;
      hits     += r.in_window;
      finished += r.run_done;
      awaited_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("pph check at %0t: %s", $time, what);
    endtask

    task check_result(hist_result_t got);
      hist_result_t want;
      if (awaited_results.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      if (got.interval !== want.interval)
        report($sformatf("result %0d: interval %0h, predicted %0h",
                         checked, got.interval, want.interval));
      if (got.in_window !== want.in_window)
        report($sformatf("result %0d: in_window %0b, predicted %0b",
                         checked, got.in_window, want.in_window));
      if (got.bin_index !== want.bin_index)
        report($sformatf("result %0d: bin_index %0d, predicted %0d",
                         checked, got.bin_index, want.bin_index));
      if (got.bin_period !== want.bin_period)
        report($sformatf("result %0d: bin_period %0d, predicted %0d",
                         checked, got.bin_period, want.bin_period));
      if (got.bin_count !== want.bin_count)
        report($sformatf("result %0d: bin_count %0d, predicted %0d",
                         checked, got.bin_count, want.bin_count));
      if (got.run_done !== want.run_done)
        report($sformatf("result %0d: run_done %0b, predicted %0b",
                         checked, got.run_done, want.run_done));
    endtask
  endclass

endpackage

FILE: tb/tb_pulse_period_histogram.sv
// Top of the pulse period histogram testbench: clock, reset, request and result
// handshakes, directed and random stimulus and the final verdict.
// Depends on pph_pkg, pph_tb_pkg and the pulse_period_histogram RTL.
module tb_pulse_period_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TS_W         = pph_pkg::TS_W;
  localparam int unsigned SEL_W        = pph_pkg::SEL_W;
  localparam int unsigned CFG_W        = pph_pkg::CFG_W;
  localparam int unsigned HIST_BINS    = pph_tb_pkg::HIST_BINS;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [CFG_W-1:0]             cfg_wr_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   in_cmd;
  logic [TS_W-1:0]              in_timestamp;
  logic [SEL_W-1:0]             in_bin_select;
  logic                         out_valid;
  logic                         out_ready;
  logic [TS_W-1:0]              out_interval;
  logic                         out_in_window;
  logic [SEL_W-1:0]             out_bin_index;
  logic [pph_pkg::PERIOD_W-1:0] out_bin_period;
  logic [pph_pkg::COUNT_W-1:0]  out_bin_count;
  logic                         out_run_done;

  pph_tb_pkg::histogram_scoreboard sb;
  idle_mode_t          mode = IDLE_NONE;
  int unsigned         hold_left = 0;
  int unsigned         cycle_count = 0;
  int unsigned         cfg_writes = 0;
  int unsigned         phase_items [4] = '{400, 300, 300, 225};

  pulse_period_histogram #(
    .NUM_BINS      (pph_tb_pkg::HIST_BINS),
    .MAX_INTERVALS (pph_tb_pkg::RUN_LENGTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_timestamp   (in_timestamp),
    .in_bin_select  (in_bin_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_interval   (out_interval),
    .out_in_window  (out_in_window),
    .out_bin_index  (out_bin_index),
    .out_bin_period (out_bin_period),
    .out_bin_count  (out_bin_count),
    .out_run_done   (out_run_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit sender_idles();
    return (mode == IDLE_SENDER && $urandom_range(99) < 81) ||
           (mode == IDLE_BOTH && $urandom_range(99) < 6);
  endfunction

  function automatic bit receiver_stalls();
    return (mode == IDLE_RECEIVER && $urandom_range(99) < 81) ||
           (mode == IDLE_BOTH && $urandom_range(99) < 6);
  endfunction

  task automatic send_request(input pph_pkg::cmd_t c, input logic [TS_W-1:0] stamp,
                              input logic [SEL_W-1:0] sel);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_timestamp  <= stamp;
    in_bin_select <= sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, stamp, sel);
  endtask

  task automatic capture_after(input logic [TS_W-1:0] delta);
    send_request(pph_pkg::CMD_CAPTURE, sb.last_stamp + delta, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.period = value;
    cfg_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // Most captures follow the previous one by an interval inside the window; the
  // rest sit just outside it, jump anywhere or drop back to an unprimed zero.
  task automatic send_random_request();
    int unsigned      roll;
    int unsigned      pick;
    logic [TS_W-1:0]  base;
    logic [TS_W-1:0]  stamp;
    logic [SEL_W-1:0] sel;
    roll  = $urandom_range(999);
    base  = sb.window_base();
    stamp = $urandom;
    sel   = SEL_W'($urandom);
    if (sb.run_over() && roll < 30) begin
      send_request(pph_pkg::CMD_START, stamp, sel);
    end else if (roll < 70) begin
      if ($urandom_range(9) != 0) sel = SEL_W'($urandom_range(HIST_BINS - 1));
      send_request(pph_pkg::CMD_READ, stamp, sel);
    end else if (roll < 80) begin
      send_request(pph_pkg::CMD_NONE, stamp, sel);
    end else begin
      pick = $urandom_range(99);
      if (pick < 72)
        stamp = sb.last_stamp + base + $urandom_range(HIST_BINS - 1);
      else if (pick < 82)
        stamp = sb.last_stamp + base - $urandom_range(3, 1);
      else if (pick < 90)
        stamp = sb.last_stamp + base + HIST_BINS + $urandom_range(3);
      else if (pick >= 97)
        stamp = '0;
      send_request(pph_pkg::CMD_CAPTURE, stamp, sel);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) hold_left--;
    out_ready <= (hold_left == 0) && !receiver_stalls();
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(pph_tb_pkg::hist_result_t'({out_interval, out_in_window,
                                                  out_bin_index, out_bin_period,
                                                  out_bin_count, out_run_done}));
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, sb.awaited_results.size());
      $display("pulse_period_histogram: mismatch");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_cmd        <= pph_pkg::CMD_NONE;
    in_timestamp  <= '0;
    in_bin_select <= '0;
    out_ready     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(pph_pkg::CMD_READ, '0, 7'd0);
    send_request(pph_pkg::CMD_CAPTURE, '0, '0);
    send_request(pph_pkg::CMD_CAPTURE, 32'hFFFF_FF00, '0);
    capture_after(950);
    capture_after(1049);
    capture_after(949);
    capture_after(1050);
    capture_after(950);
    capture_after(950);
    send_request(pph_pkg::CMD_READ, '0, 7'd0);
    send_request(pph_pkg::CMD_READ, '0, 7'd99);
    send_request(pph_pkg::CMD_READ, '1, 7'd100);
    send_request(pph_pkg::CMD_READ, '1, 7'd127);
    send_request(pph_pkg::CMD_NONE, '1, 7'd127);
    send_request(pph_pkg::CMD_START, '1, '1);
    capture_after(0);
    capture_after('1);
    write_period(16'd0);
    capture_after(0);
    capture_after(99);
    capture_after(100);
    send_request(pph_pkg::CMD_READ, '0, 7'd127);
    write_period(16'hFFFF);
    capture_after(65485);
    capture_after(65584);
    send_request(pph_pkg::CMD_READ, '0, 7'd99);
    send_request(pph_pkg::CMD_READ, '0, 7'd127);
    write_period(16'd50);
    capture_after(0);

    foreach (phase_items[p]) begin
      case (p)
        0:       write_period(pph_pkg::PERIOD_DEFAULT);
        1:       write_period(CFG_W'($urandom_range(65535, 50)));
        2:       write_period(CFG_W'($urandom_range(49)));
        default: write_period(CFG_W'($urandom_range(3000, 50)));
      endcase
      mode = idle_mode_t'(p);
      // The receiver holds off long enough for the pipeline to fill and stall requests.
      if (p == 0) hold_left = 200;
      repeat (phase_items[p]) send_random_request();
    end
    wait_drained();

    $display("Checked %0d results for %0d requests across %0d expected-period writes",
             sb.checked, sb.requests, cfg_writes);
    $display("and four idling patterns; %0d intervals hit a bin, %0d finished-run results.",
             sb.hits, sb.finished);
    if (sb.errors == 0) begin
      $display("pulse_period_histogram: match");
    end else begin
      $display("pulse_period_histogram: mismatch");
    end
    $finish;
  end

endmodule
